// ----- src/bgd_pkg.sv -----
// Shared types, codes and reset constants for the button gesture decoder.
// No dependencies; every other file in src uses this package.
package bgd_pkg;

    // Widths fixed by the field definitions.
    localparam int CFG_W     = 16;
    localparam int EV_W      = 3;
    localparam int CLICK_W   = 2;
    localparam int CFG_IDX_W = 2;

    // Default width of the processed-tick counter and time stamps.
    localparam int TIME_BITS_DEF = 32;

    // Event codes.
    localparam logic [EV_W-1:0] EV_NONE   = 3'd0;
    localparam logic [EV_W-1:0] EV_SINGLE = 3'd1;
    localparam logic [EV_W-1:0] EV_TRIPLE = 3'd2;
    localparam logic [EV_W-1:0] EV_HELP   = 3'd3;
    localparam logic [EV_W-1:0] EV_CONFIG = 3'd4;
    localparam logic [EV_W-1:0] EV_EXIT   = 3'd5;

    // Click count that makes a triple click.
    localparam logic [CLICK_W-1:0] TRIPLE_COUNT = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HELP     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 2'd3;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CFG_W-1:0] WINDOW_RST   = 16'd800;
    localparam logic [CFG_W-1:0] HELP_RST     = 16'd2000;
    localparam logic [CFG_W-1:0] HOLD_RST     = 16'd3000;

    // Configuration register set.
    typedef struct packed {
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] click_window_ticks;
        logic [CFG_W-1:0] help_hold_ticks;
        logic [CFG_W-1:0] config_hold_ticks;
    } t_cfg;

    // Accepted edges of the debounced level for one tick.
    typedef struct packed {
        logic press;
        logic release_edge;
    } t_edge;

endpackage

// ----- src/bgd_debounce.sv -----
// Tick counter, raw level debounce and edge finder of the debounced level.
// Depends on bgd_pkg.
module bgd_debounce #(
    parameter int TIME_BITS = bgd_pkg::TIME_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic                         i_raw_level,
    input  logic [bgd_pkg::CFG_W-1:0]    i_debounce_ticks,
    output logic [TIME_BITS-1:0]         o_now,
    output bgd_pkg::t_edge               o_edge,
    output logic                         o_stable_level
);

    logic [TIME_BITS-1:0] r_tick;
    logic                 r_last_raw;
    logic                 r_last_stable;
    logic [TIME_BITS-1:0] r_change_time;

    logic [TIME_BITS-1:0] n_change_time;
    logic [TIME_BITS-1:0] quiet_time;
    logic                 settled;
    logic                 stable_edge;
    logic                 n_stable;

    // A raw change restarts the quiet interval on this very tick.
    always_comb begin
        n_change_time = (i_raw_level != r_last_raw) ? r_tick : r_change_time;
        quiet_time    = r_tick - n_change_time;
        settled       = quiet_time >= TIME_BITS'(i_debounce_ticks);
        stable_edge   = settled && (i_raw_level != r_last_stable);
        n_stable      = stable_edge ? i_raw_level : r_last_stable;
    end

    assign o_now               = r_tick;
    assign o_edge.press        = stable_edge && !i_raw_level;
    assign o_edge.release_edge = stable_edge && i_raw_level;
    assign o_stable_level      = n_stable;

    // Debounce state advances once per processed tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick        <= '0;
            r_last_raw    <= 1'b1;
            r_last_stable <= 1'b1;
            r_change_time <= '0;
        end else if (i_fire) begin
            r_tick        <= r_tick + TIME_BITS'(1);
            r_last_raw    <= i_raw_level;
            r_last_stable <= n_stable;
            r_change_time <= n_change_time;
        end
    end

endmodule

// ----- src/bgd_gesture.sv -----
// Click window counting, hold detection and event selection for one tick.
// Depends on bgd_pkg; fed by bgd_debounce.
module bgd_gesture #(
    parameter int TIME_BITS = bgd_pkg::TIME_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_fire,
    input  logic [TIME_BITS-1:0]           i_now,
    input  bgd_pkg::t_edge                 i_edge,
    input  logic                           i_in_config_mode,
    input  logic                           i_config_guard_elapsed,
    input  bgd_pkg::t_cfg                  i_cfg,
    output logic [bgd_pkg::EV_W-1:0]       o_event,
    output logic [bgd_pkg::CLICK_W-1:0]    o_clicks
);

    logic                          r_pressed;
    logic                          r_hold_fired;
    logic [TIME_BITS-1:0]          r_press_start;
    logic [bgd_pkg::CLICK_W-1:0]   r_clicks;
    logic [TIME_BITS-1:0]          r_win_start;

    logic                          n_pressed;
    logic                          n_hold_fired;
    logic [TIME_BITS-1:0]          n_press_start;
    logic [bgd_pkg::CLICK_W-1:0]   n_clicks;
    logic [TIME_BITS-1:0]          n_win_start;

    logic [TIME_BITS-1:0]          win_elapsed;
    logic                          win_over;
    logic [bgd_pkg::CLICK_W-1:0]   clicks_inc;
    logic [bgd_pkg::EV_W-1:0]      edge_ev;
    logic [bgd_pkg::EV_W-1:0]      hold_ev;
    logic [TIME_BITS-1:0]          hold_dur;

    assign win_elapsed = i_now - r_win_start;
    assign win_over    = win_elapsed > TIME_BITS'(i_cfg.click_window_ticks);
    assign clicks_inc  = (r_clicks < bgd_pkg::TRIPLE_COUNT) ? r_clicks + 2'd1 : r_clicks;

    // Edge handling, then the hold check on the updated state.
    always_comb begin
        n_pressed     = r_pressed;
        n_hold_fired  = r_hold_fired;
        n_press_start = r_press_start;
        n_clicks      = r_clicks;
        n_win_start   = r_win_start;
        edge_ev       = bgd_pkg::EV_NONE;
        hold_ev       = bgd_pkg::EV_NONE;

        if (i_edge.press) begin
            n_pressed     = 1'b1;
            n_hold_fired  = 1'b0;
            n_press_start = i_now;
            if (r_clicks == '0 || win_over) begin
                n_clicks    = '0;
                n_win_start = i_now;
            end
        end else if (i_edge.release_edge) begin
            n_pressed = 1'b0;
            if (i_in_config_mode && i_config_guard_elapsed) begin
                // Leaving config mode touches neither the window nor the hold flag.
                edge_ev = bgd_pkg::EV_EXIT;
            end else if (r_hold_fired) begin
                n_hold_fired = 1'b0;
                n_clicks     = '0;
                n_win_start  = '0;
            end else if (clicks_inc >= bgd_pkg::TRIPLE_COUNT && !win_over) begin
                edge_ev     = bgd_pkg::EV_TRIPLE;
                n_clicks    = '0;
                n_win_start = '0;
            end else begin
                edge_ev  = bgd_pkg::EV_SINGLE;
                n_clicks = clicks_inc;
                if (win_over) begin
                    n_clicks    = '0;
                    n_win_start = '0;
                end
            end
        end

        // A press edge restarts the hold timer, so a zero hold length fires at once.
        hold_dur = i_now - n_press_start;
        if (n_pressed && !n_hold_fired) begin
            if (n_clicks == 2'd1 &&
                hold_dur >= TIME_BITS'(i_cfg.config_hold_ticks)) begin
                hold_ev      = bgd_pkg::EV_CONFIG;
                n_hold_fired = 1'b1;
                n_clicks     = '0;
                n_win_start  = '0;
            end else if (n_clicks == '0 &&
                         hold_dur >= TIME_BITS'(i_cfg.help_hold_ticks)) begin
                hold_ev      = bgd_pkg::EV_HELP;
                n_hold_fired = 1'b1;
                n_clicks     = '0;
                n_win_start  = '0;
            end
        end

        o_event  = (edge_ev != bgd_pkg::EV_NONE) ? edge_ev : hold_ev;
        o_clicks = n_clicks;
    end

    // Gesture state advances once per processed tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed     <= 1'b0;
            r_hold_fired  <= 1'b0;
            r_press_start <= '0;
            r_clicks      <= '0;
            r_win_start   <= '0;
        end else if (i_fire) begin
            r_pressed     <= n_pressed;
            r_hold_fired  <= n_hold_fired;
            r_press_start <= n_press_start;
            r_clicks      <= n_clicks;
            r_win_start   <= n_win_start;
        end
    end

endmodule

// ----- src/button_gesture_decoder.sv -----
// Top level of the button gesture decoder: input register, configuration
// registers, result register. Depends on bgd_pkg, bgd_debounce, bgd_gesture.
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+----------------------------------------
//  in      | input     | i_in_valid/o_in_ready  | i_raw_level, i_in_config_mode,
//          |           |                        | i_config_guard_elapsed
//  out     | output    | o_out_valid/i_out_ready| o_event_res, o_stable_level, o_click_count
//  cfg     | input     | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// Each tick beat passes from the input register through the debounce and gesture
// logic into the result register. One beat per cycle is sustained while the
// result register is not held; the state update of one tick is a single pass
// of subtract-and-compare logic. Synchronous reset restores the default
// configuration and the released, idle state. While the result register is held,
// the input register still takes one more beat; the configuration port is always ready.
module button_gesture_decoder #(
    parameter int TIME_BITS = bgd_pkg::TIME_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_raw_level,
    input  logic                             i_in_config_mode,
    input  logic                             i_config_guard_elapsed,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [bgd_pkg::EV_W-1:0]         o_event_res,
    output logic                             o_stable_level,
    output logic [bgd_pkg::CLICK_W-1:0]      o_click_count,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bgd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bgd_pkg::CFG_W-1:0]        i_cfg_data
);

    bgd_pkg::t_cfg                  r_cfg;
    logic                           r_in_vld;
    logic                           r_raw;
    logic                           r_cfg_mode;
    logic                           r_guard;
    logic                           r_out_vld;
    logic [bgd_pkg::EV_W-1:0]       r_event;
    logic                           r_stable;
    logic [bgd_pkg::CLICK_W-1:0]    r_clicks;

    logic                           fire;
    logic [TIME_BITS-1:0]           now;
    bgd_pkg::t_edge                 edges;
    logic                           stable_n;
    logic [bgd_pkg::EV_W-1:0]       event_n;
    logic [bgd_pkg::CLICK_W-1:0]    clicks_n;

    // A held beat moves on when the result register is free or being emptied.
    assign fire        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || fire;
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks     <= bgd_pkg::DEBOUNCE_RST;
            r_cfg.click_window_ticks <= bgd_pkg::WINDOW_RST;
            r_cfg.help_hold_ticks    <= bgd_pkg::HELP_RST;
            r_cfg.config_hold_ticks  <= bgd_pkg::HOLD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bgd_pkg::CFG_DEBOUNCE: r_cfg.debounce_ticks     <= i_cfg_data;
                bgd_pkg::CFG_WINDOW:   r_cfg.click_window_ticks <= i_cfg_data;
                bgd_pkg::CFG_HELP:     r_cfg.help_hold_ticks    <= i_cfg_data;
                bgd_pkg::CFG_HOLD:     r_cfg.config_hold_ticks  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_raw      <= i_raw_level;
            r_cfg_mode <= i_in_config_mode;
            r_guard    <= i_config_guard_elapsed;
        end
    end

    bgd_debounce #(
        .TIME_BITS (TIME_BITS)
    ) u_debounce (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (fire),
        .i_raw_level      (r_raw),
        .i_debounce_ticks (r_cfg.debounce_ticks),
        .o_now            (now),
        .o_edge           (edges),
        .o_stable_level   (stable_n)
    );

    bgd_gesture #(
        .TIME_BITS (TIME_BITS)
    ) u_gesture (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_fire                 (fire),
        .i_now                  (now),
        .i_edge                 (edges),
        .i_in_config_mode       (r_cfg_mode),
        .i_config_guard_elapsed (r_guard),
        .i_cfg                  (r_cfg),
        .o_event                (event_n),
        .o_clicks               (clicks_n)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_event  <= event_n;
            r_stable <= stable_n;
            r_clicks <= clicks_n;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_event_res    = r_event;
    assign o_stable_level = r_stable;
    assign o_click_count  = r_clicks;

`ifndef ASSERT_OFF
    // A triple click or a hold gesture always closes the click window.
    a_window_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_event_res == bgd_pkg::EV_TRIPLE ||
                         o_event_res == bgd_pkg::EV_HELP ||
                         o_event_res == bgd_pkg::EV_CONFIG)) |-> (o_click_count == '0))
        else $error("gesture event left clicks in the window");

    // Click and exit events come only from a release, so the level is released.
    a_release_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_event_res == bgd_pkg::EV_SINGLE ||
                         o_event_res == bgd_pkg::EV_TRIPLE ||
                         o_event_res == bgd_pkg::EV_EXIT)) |-> o_stable_level)
        else $error("release event with pressed stable level");

    // Hold events are raised only while the button is down.
    a_hold_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_event_res == bgd_pkg::EV_HELP ||
                         o_event_res == bgd_pkg::EV_CONFIG)) |-> !o_stable_level)
        else $error("hold event with released stable level");

    // A full input register behind a stalled result takes no new beat.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_out_vld && !i_out_ready) |=> (r_in_vld && $stable(r_raw)))
        else $error("input beat lost while the result was stalled");
`endif

endmodule
